// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with a reset qualifier.
`define QAB_ASSERT_RST(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("qab assertion failed");

// Concurrent assertion that also holds through reset.
`define QAB_ASSERT(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("qab assertion failed");

`endif

// ===== rtl/qab_pkg.sv =====
// Types and constants for the quaternion angle binning block.
// No dependencies.
`timescale 1ns / 1ps

package qab_pkg;

  localparam int QW = 16;   // quaternion component width
  localparam int AW = 34;   // product accumulators
  localparam int XW = 40;   // CORDIC x/y datapath
  localparam int ZW = 34;   // binary angle, 2^32 per turn
  localparam int BW = 5;    // bin index
  localparam int DW = 6;    // signed bin change
  localparam int SVW = 57;  // radicand width
  localparam int SRW = 29;  // root width
  localparam int SW = 30;   // clamped pitch term

  localparam logic [BW-1:0] ANGLE_BINS_RESET = 5'd18;

  localparam logic signed [XW-1:0] ONE_Q28 = 40'sd268435456;
  localparam logic signed [SW-1:0] S_MAX = 30'sd268435456;
  localparam logic signed [SW-1:0] S_MIN = -30'sd268435456;
  localparam logic [SVW-1:0] SQ_ONE = {1'b1, {(SVW-1){1'b0}}};

  localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [35:0] QUARTER_TURN36 = 36'sd1073741824;
  localparam logic signed [35:0] HALF_TURN36 = 36'sd2147483648;

  localparam logic [29:0] ATAN_TURNS [24] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
    30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
    30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef logic [BW-1:0] bin_t;
  typedef logic signed [DW-1:0] delta_t;

endpackage

// ===== rtl/qab_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on qab_pkg.
`timescale 1ns / 1ps

module qab_isqrt import qab_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [SVW-1:0] radicand,
  output logic           done,
  output logic [SRW-1:0] root
);

  logic           busy;
  logic [SVW-1:0] rem;
  logic [SVW:0]   res;
  logic [SVW:0]   sbit;
  logic [SVW:0]   trial;

  assign trial = res + sbit;
  assign root  = res[SRW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        rem  <= radicand;
        res  <= '0;
        sbit <= {2'b01, {(SVW-1){1'b0}}};
      end else if (busy) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[SVW-1:0];
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
        if (sbit[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/qab_cordic.sv =====
// Shared vectoring CORDIC: atan2(y, x) as a binary angle, one step per cycle.
// Depends on qab_pkg.
`timescale 1ns / 1ps

module qab_cordic import qab_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [XW-1:0] x_in,
  output logic                 done,
  output logic signed [ZW-1:0] angle
);

  localparam int IW = $clog2(STEPS);

  logic                 busy;
  logic [IW-1:0]        step;
  logic signed [XW-1:0] x, y, dx, dy;
  logic signed [ZW-1:0] z, atan_z;
  logic [4:0]           idx;

  assign idx    = 5'(step);
  assign dx     = y >>> step;
  assign dy     = x >>> step;
  assign atan_z = $signed({{(ZW-30){1'b0}}, ATAN_TURNS[idx]});
  assign angle  = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        step <= '0;
        if (x_in == '0 && y_in == '0) begin
          z    <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          done <= 1'b0;
          if (x_in < 0) begin
            // fold the left half plane in by a quarter turn
            if (y_in >= 0) begin
              x <= y_in;
              y <= -x_in;
              z <= QUARTER_TURN;
            end else begin
              x <= -y_in;
              y <= x_in;
              z <= -QUARTER_TURN;
            end
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_z;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_z;
        end
        if (step == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/quaternion_to_angle_bins_unit.sv =====
// Quaternion to angle bins: one orientation sample in, six bin changes out. Each
// item runs the component products on the shared multiplier, the square of the
// pitch term, the bit-pair root loop, three runs of the shared CORDIC unit, the
// bin products on the multiplier and the report, in that order. in_stall stays
// high for the whole of that; a finished item waits in the output register, so
// the next sample may start while it is not taken.
// Depends on qab_pkg, qab_isqrt and qab_cordic.
`timescale 1ns / 1ps

module quaternion_to_angle_bins_unit import qab_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [BW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 device_select,
  input  logic signed [QW-1:0] quat_w,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output delta_t               left_roll_change,
  output delta_t               left_pitch_change,
  output delta_t               left_yaw_change,
  output delta_t               right_roll_change,
  output delta_t               right_pitch_change,
  output delta_t               right_yaw_change
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT,
    ST_CORD_GO, ST_CORD_WAIT, ST_BIN, ST_FIN
  } state_t;

  state_t state;
  logic [3:0] cnt;
  logic [1:0] run;

  logic [BW-1:0] angle_bins;
  logic dev;
  logic signed [QW-1:0] qw, qx, qy, qz;
  logic signed [AW-1:0] acc_ry, acc_rx, acc_s, acc_yy, acc_yx;
  logic signed [SW-1:0] s_q;
  logic [SRW-1:0] c_q;
  logic signed [ZW-1:0] ang [3];
  bin_t cur [6];
  bin_t rep [6];

  // shared multiplier, registered product
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] prod;
  logic signed [AW-1:0] p;

  assign mul_p = mul_a * mul_b;
  assign p     = prod[AW-1:0];

  // clamped pitch term, 2*(wy - zx) in Q28
  logic signed [AW:0] s_full;
  logic signed [SW-1:0] s_clamp;
  assign s_full = {acc_s, 1'b0};
  always_comb begin
    if (s_full > (AW+1)'(S_MAX))      s_clamp = S_MAX;
    else if (s_full < (AW+1)'(S_MIN)) s_clamp = S_MIN;
    else                              s_clamp = s_full[SW-1:0];
  end

  // binning operand: shift the angle to the bottom of its span, doubling pitch, then clamp
  logic signed [35:0] u_full;
  logic [31:0] u_sel;
  always_comb begin
    case (cnt)
      4'd1:    u_full = (36'(ang[1]) + QUARTER_TURN36) <<< 1;
      4'd2:    u_full = 36'(ang[2]) + HALF_TURN36;
      default: u_full = 36'(ang[0]) + HALF_TURN36;
    endcase
    if (u_full < 0)              u_sel = '0;
    else if (u_full[35:32] != 0) u_sel = '1;
    else                         u_sel = u_full[31:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PROD: begin
        case (cnt)
          4'd0:    begin mul_a = 33'(qw); mul_b = 33'(qx); end
          4'd1:    begin mul_a = 33'(qy); mul_b = 33'(qz); end
          4'd2:    begin mul_a = 33'(qx); mul_b = 33'(qx); end
          4'd3:    begin mul_a = 33'(qy); mul_b = 33'(qy); end
          4'd4:    begin mul_a = 33'(qw); mul_b = 33'(qy); end
          4'd5:    begin mul_a = 33'(qz); mul_b = 33'(qx); end
          4'd6:    begin mul_a = 33'(qw); mul_b = 33'(qz); end
          4'd7:    begin mul_a = 33'(qx); mul_b = 33'(qy); end
          4'd8:    begin mul_a = 33'(qz); mul_b = 33'(qz); end
          default: ;
        endcase
      end
      ST_SQ: begin
        mul_a = 33'(s_q);
        mul_b = 33'(s_q);
      end
      ST_BIN: begin
        mul_a = $signed({1'b0, u_sel});
        mul_b = $signed({28'd0, angle_bins});
      end
      default: ;
    endcase
  end

  // root of 1 - s^2 for the pitch cosine
  logic sqrt_done;
  logic [SRW-1:0] sqrt_root;
  logic [SVW-1:0] radicand;
  assign radicand = SQ_ONE - prod[SVW-1:0];

  qab_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_SQRT_GO),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // CORDIC operands: roll, then pitch, then yaw
  logic signed [XW-1:0] cy, cx;
  always_comb begin
    case (run)
      2'd0: begin
        cy = XW'(acc_ry) <<< 1;
        cx = ONE_Q28 - (XW'(acc_rx) <<< 1);
      end
      2'd1: begin
        cy = XW'(s_q);
        cx = $signed({{(XW-SRW){1'b0}}, c_q});
      end
      default: begin
        cy = XW'(acc_yy) <<< 1;
        cx = ONE_Q28 - (XW'(acc_yx) <<< 1);
      end
    endcase
  end

  logic cord_done;
  logic signed [ZW-1:0] cord_angle;

  qab_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_CORD_GO),
    .y_in  (cy),
    .x_in  (cx),
    .done  (cord_done),
    .angle (cord_angle)
  );

  logic [2:0] slot;
  assign slot = (dev ? 3'd3 : 3'd0) + 3'(cnt - 4'd1);

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    prod <= mul_p[63:0];
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      run        <= '0;
      out_valid  <= 1'b0;
      angle_bins <= ANGLE_BINS_RESET;
      for (int k = 0; k < 6; k++) begin
        cur[k] <= '0;
        rep[k] <= '0;
      end
    end else begin
      if (cfg_write) angle_bins <= cfg_data;
      // raise on a report, drop once the waiting item is taken
      if (state == ST_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall)                               out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dev    <= device_select;
            qw     <= quat_w;
            qx     <= quat_x;
            qy     <= quat_y;
            qz     <= quat_z;
            acc_ry <= '0;
            acc_rx <= '0;
            acc_s  <= '0;
            acc_yy <= '0;
            acc_yx <= '0;
            cnt    <= '0;
            state  <= ST_PROD;
          end
        end
        ST_PROD: begin
          // fold in the product issued the cycle before
          case (cnt) inside
            4'd1, 4'd2: acc_ry <= acc_ry + p;
            4'd3:       acc_rx <= acc_rx + p;
            4'd4: begin
              acc_rx <= acc_rx + p;
              acc_yx <= acc_yx + p;
            end
            4'd5:       acc_s  <= acc_s + p;
            4'd6:       acc_s  <= acc_s - p;
            4'd7, 4'd8: acc_yy <= acc_yy + p;
            4'd9:       acc_yx <= acc_yx + p;
            default: ;
          endcase
          if (cnt == 4'd9) begin
            s_q   <= s_clamp;
            state <= ST_SQ;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_SQ: state <= ST_SQRT_GO;
        ST_SQRT_GO: state <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            c_q   <= sqrt_root;
            run   <= '0;
            state <= ST_CORD_GO;
          end
        end
        ST_CORD_GO: state <= ST_CORD_WAIT;
        ST_CORD_WAIT: begin
          if (cord_done) begin
            ang[run] <= cord_angle;
            if (run == 2'd2) begin
              cnt   <= '0;
              state <= ST_BIN;
            end else begin
              run   <= run + 2'd1;
              state <= ST_CORD_GO;
            end
          end
        end
        ST_BIN: begin
          // bin = top bits of u * angle_bins
          if (cnt != 4'd0) cur[slot] <= prod[36:32];
          if (cnt == 4'd3) state <= ST_FIN;
          else             cnt <= cnt + 4'd1;
        end
        ST_FIN: begin
          // hold until the output register is free, then report
          if (!out_valid || !out_stall) begin
            left_roll_change   <= $signed({1'b0, cur[0]}) - $signed({1'b0, rep[0]});
            left_pitch_change  <= $signed({1'b0, cur[1]}) - $signed({1'b0, rep[1]});
            left_yaw_change    <= $signed({1'b0, cur[2]}) - $signed({1'b0, rep[2]});
            right_roll_change  <= $signed({1'b0, cur[3]}) - $signed({1'b0, rep[3]});
            right_pitch_change <= $signed({1'b0, cur[4]}) - $signed({1'b0, rep[4]});
            right_yaw_change   <= $signed({1'b0, cur[5]}) - $signed({1'b0, rep[5]});
            for (int k = 0; k < 6; k++) rep[k] <= cur[k];
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/qab_checker.sv =====
// Port-level checks for quaternion_to_angle_bins_unit, bound to the top level.
// Depends on qab_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qab_checker import qab_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_stall,
  input logic   out_valid,
  input logic   out_stall,
  input delta_t left_roll_change,
  input delta_t left_pitch_change,
  input delta_t left_yaw_change,
  input delta_t right_roll_change,
  input delta_t right_pitch_change,
  input delta_t right_yaw_change
);

  // an accepted item keeps the block busy
  `QAB_ASSERT_RST(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> in_stall)

  // a new result only comes out of a busy cycle
  `QAB_ASSERT_RST(a_result_from_work, clk, rst, $rose(out_valid) |-> $past(in_stall))

  // reset leaves nothing pending and the input open
  `QAB_ASSERT(a_reset_clean, clk, rst |=> !out_valid && !in_stall)

  // a stalled result holds
  `QAB_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(left_roll_change) && $stable(left_pitch_change) && $stable(left_yaw_change) && $stable(right_roll_change) && $stable(right_pitch_change) && $stable(right_yaw_change))

endmodule

bind quaternion_to_angle_bins_unit qab_checker u_qab_checker (.*);
